### sv/mm_pkg.sv
// shared constants, types and helpers for the matrix multiply block
`default_nettype none

package mm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int FRAC_BITS   = 16;

  localparam int ELEM_W      = 32;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = 3;
  localparam int REG_IDX_W   = 2;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int ACC_W       = PROD_W + $clog2(MAX_DIM);

  localparam logic [REG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B = 2'd2;

  localparam logic [0:0] REQ_A = 1'b0;
  localparam logic [0:0] REQ_B = 1'b1;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic              first;
    logic              last_k;
    logic              last_elem;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_out;
  } dp_status_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/mm_ctrl.sv
// controller: config registers, load counters and compute sequencer
`default_nettype none

module mm_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          req_type,
  input  wire logic                          cfg_we,
  input  wire logic [mm_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [mm_pkg::DIM_W-1:0]      cfg_data,
  input  wire mm_pkg::dp_status_t            status,
  output logic                               busy,
  output mm_pkg::ctrl_cmd_t                  cmd
);
  import mm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state, state_next;
  logic [DIM_W-1:0] rows_a, inner, cols_b;
  logic [DIM_W-1:0] nr, nk, nc;
  logic [CNT_W-1:0] a_size, b_size;
  logic [CNT_W-1:0] a_cnt, a_cnt_next, b_cnt, b_cnt_next;
  logic [IDX_W-1:0] i_cnt, i_next, j_cnt, j_next, k_cnt, k_next;
  logic             accept, a_room, b_room, last_i, last_j, last_k;
  logic [CNT_W-1:0] a_addr_full, b_addr_full;

  assign nr     = eff_dim(rows_a);
  assign nk     = eff_dim(inner);
  assign nc     = eff_dim(cols_b);
  assign a_size = CNT_W'(nr) * CNT_W'(nk);
  assign b_size = CNT_W'(nk) * CNT_W'(nc);

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);
  assign a_room = (a_cnt < a_size);
  assign b_room = (b_cnt < b_size);

  assign last_i = ((DIM_W'(i_cnt) + DIM_W'(1)) == nr);
  assign last_j = ((DIM_W'(j_cnt) + DIM_W'(1)) == nc);
  assign last_k = ((DIM_W'(k_cnt) + DIM_W'(1)) == nk);

  assign a_addr_full = CNT_W'(i_cnt) * CNT_W'(nk) + CNT_W'(k_cnt);
  assign b_addr_full = CNT_W'(k_cnt) * CNT_W'(nc) + CNT_W'(j_cnt);

  always_comb begin
    state_next = state;
    a_cnt_next = a_cnt;
    b_cnt_next = b_cnt;
    i_next     = i_cnt;
    j_next     = j_cnt;
    k_next     = k_cnt;

    cmd           = '0;
    cmd.wr_addr   = (req_type == REQ_B) ? b_cnt[ADDR_W-1:0] : a_cnt[ADDR_W-1:0];
    cmd.rd_a_addr = a_addr_full[ADDR_W-1:0];
    cmd.rd_b_addr = b_addr_full[ADDR_W-1:0];
    cmd.row       = i_cnt;
    cmd.col       = j_cnt;
    cmd.first     = (k_cnt == '0);
    cmd.last_k    = last_k;
    cmd.last_elem = last_i && last_j && last_k;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_A && a_room) begin
            cmd.wr_a   = 1'b1;
            a_cnt_next = a_cnt + CNT_W'(1);
          end
          if (req_type == REQ_B && b_room) begin
            cmd.wr_b   = 1'b1;
            b_cnt_next = b_cnt + CNT_W'(1);
          end
          if (a_cnt_next >= a_size && b_cnt_next >= b_size) begin
            state_next = ST_RUN;
            a_cnt_next = '0;
            b_cnt_next = '0;
            i_next     = '0;
            j_next     = '0;
            k_next     = '0;
          end
        end
      end
      ST_RUN: begin
        cmd.rd_en = 1'b1;
        if (last_k) begin
          k_next = '0;
          if (last_j) begin
            j_next = '0;
            if (last_i) begin
              state_next = ST_DRAIN;
            end else begin
              i_next = i_cnt + IDX_W'(1);
            end
          end else begin
            j_next = j_cnt + IDX_W'(1);
          end
        end else begin
          k_next = k_cnt + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (status.last_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      a_cnt  <= '0;
      b_cnt  <= '0;
      i_cnt  <= '0;
      j_cnt  <= '0;
      k_cnt  <= '0;
      rows_a <= DIM_W'(MAX_DIM);
      inner  <= DIM_W'(MAX_DIM);
      cols_b <= DIM_W'(MAX_DIM);
    end else begin
      state <= state_next;
      a_cnt <= a_cnt_next;
      b_cnt <= b_cnt_next;
      i_cnt <= i_next;
      j_cnt <= j_next;
      k_cnt <= k_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS_A: rows_a <= cfg_data;
          REG_INNER:  inner  <= cfg_data;
          REG_COLS_B: cols_b <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### sv/mm_dpath.sv
// datapath: element stores, multiply-accumulate pipeline and saturating output
`default_nettype none

module mm_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [mm_pkg::ELEM_W-1:0]  elem_value,
  input  wire mm_pkg::ctrl_cmd_t          cmd,
  output mm_pkg::dp_status_t              status,
  output logic                            done,
  output logic [mm_pkg::ELEM_W-1:0]       product_value,
  output logic [mm_pkg::IDX_W-1:0]        out_row,
  output logic [mm_pkg::IDX_W-1:0]        out_col,
  output logic                            saturated,
  output logic                            last
);
  import mm_pkg::*;

  logic [ELEM_W-1:0] a_mem [STORE_DEPTH];
  logic [ELEM_W-1:0] b_mem [STORE_DEPTH];

  logic [ELEM_W-1:0] a_q, b_q;
  logic              s1_valid, s1_first, s1_last_k, s1_last_elem;
  logic [IDX_W-1:0]  s1_row, s1_col;

  logic [PROD_W-1:0] prod;
  logic              s2_valid, s2_first, s2_last_k, s2_last_elem;
  logic [IDX_W-1:0]  s2_row, s2_col;

  logic [ACC_W-1:0]  acc, prod_ext;
  logic              s3_done, s3_last_elem;
  logic [IDX_W-1:0]  s3_row, s3_col;

  logic [ACC_W-1:0]  shifted;
  logic [ACC_W-ELEM_W:0] upper;
  logic              fits;

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[cmd.wr_addr] <= elem_value;
    end
    a_q <= a_mem[cmd.rd_a_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      b_mem[cmd.wr_addr] <= elem_value;
    end
    b_q <= b_mem[cmd.rd_b_addr];
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign shifted  = ACC_W'($signed(acc) >>> FRAC_BITS);
  assign upper    = shifted[ACC_W-1:ELEM_W-1];
  assign fits     = (upper == '0) || (upper == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_done  <= 1'b0;
      done     <= 1'b0;
      last     <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
      s3_done  <= s2_valid && s2_last_k;
      done     <= s3_done;
      last     <= s3_done && s3_last_elem;
    end
  end

  always_ff @(posedge clk) begin
    s1_first     <= cmd.first;
    s1_last_k    <= cmd.last_k;
    s1_last_elem <= cmd.last_elem;
    s1_row       <= cmd.row;
    s1_col       <= cmd.col;

    prod         <= PROD_W'($signed(a_q) * $signed(b_q));
    s2_first     <= s1_first;
    s2_last_k    <= s1_last_k;
    s2_last_elem <= s1_last_elem;
    s2_row       <= s1_row;
    s2_col       <= s1_col;

    if (s2_valid) begin
      acc <= s2_first ? prod_ext : acc + prod_ext;
    end
    s3_last_elem <= s2_last_elem;
    s3_row       <= s2_row;
    s3_col       <= s2_col;

    out_row   <= s3_row;
    out_col   <= s3_col;
    saturated <= !fits;
    if (fits) begin
      product_value <= shifted[ELEM_W-1:0];
    end else if (acc[ACC_W-1]) begin
      product_value <= {1'b1, {(ELEM_W - 1){1'b0}}};
    end else begin
      product_value <= {1'b0, {(ELEM_W - 1){1'b1}}};
    end
  end

  assign status.last_out = done && last;

endmodule

`default_nettype wire

### sv/matrix_multiply.sv
// top level of the matrix multiply block
// loads: one item per cycle while busy is low; the item that completes both
// matrices raises busy until the final result is shown, one multiply-accumulate
// per cycle through the single multiplier and one read port per store
// results: one per element of the rows x cols product, in row-major order
// reset: load counters cleared, dimensions set to MAX_DIM, stores keep their contents
`default_nettype none

module matrix_multiply (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          req_type,
  input  wire logic [mm_pkg::ELEM_W-1:0]     elem_value,
  input  wire logic                          cfg_we,
  input  wire logic [mm_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [mm_pkg::DIM_W-1:0]      cfg_data,
  output logic                               done,
  output logic [mm_pkg::ELEM_W-1:0]          product_value,
  output logic [mm_pkg::IDX_W-1:0]           out_row,
  output logic [mm_pkg::IDX_W-1:0]           out_col,
  output logic                               saturated,
  output logic                               last
);
  import mm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  mm_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .elem_value    (elem_value),
    .cmd           (cmd),
    .status        (status),
    .done          (done),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .saturated     (saturated),
    .last          (last)
  );

endmodule

`default_nettype wire

### sv/mm_checker.sv
// port-level checker for the matrix multiply block, bound to the top level
`default_nettype none

module mm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic last
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while not busy");

  a_last_done: assert property (@(posedge clk) disable iff (rst) last |-> done)
    else $error("last mark without a result");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (done && last) |=> !busy)
    else $error("still busy after the final result");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an item");

  a_reset: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("busy or result right after reset");

endmodule

bind matrix_multiply mm_checker u_mm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .last  (last)
);

`default_nettype wire
